// ===== design/ppx_pkg.sv =====
// Shared types, constants and helpers for the packed pixel access engine.
package ppx_pkg;

    // Parameter defaults
    localparam int STORE_BYTES_DEF = 262144;
    localparam int MAX_DIM_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Widest byte address over the supported store range (up to 16 MiB)
    localparam int STORE_AW_MAX = 24;
    // Width of the unchecked address sum: 13b row * 15b stride + column offset
    localparam int CALC_W = 29;
    // Store byte lanes (one 32-bit word per bank row)
    localparam int LANES = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN = 3'd3;

    typedef enum logic [2:0] {
        FMT_1BPP,
        FMT_2BPP,
        FMT_4BPP,
        FMT_8BPP,
        FMT_16BPP,
        FMT_24BPP,
        FMT_32BPP,
        FMT_NONE
    } fmt_t;

    // Image configuration as seen by the front end
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        fmt_t             fmt;
        logic             top_down;
    } ppx_cfg_t;

    // Classified access handed from front to back
    typedef struct packed {
        logic                    mode;
        logic                    good;
        fmt_t                    fmt;
        logic [2:0]              shift;
        logic [STORE_AW_MAX-1:0] addr;
        logic [PIX_W-1:0]        value;
    } ppx_cmd_t;

    // Pixel field mask inside a byte for sub-byte formats
    function automatic logic [7:0] fmt_mask(input fmt_t fmt);
        logic [7:0] m;
        unique case (fmt)
            FMT_1BPP: m = 8'h01;
            FMT_2BPP: m = 8'h03;
            FMT_4BPP: m = 8'h0F;
            default:  m = 8'hFF;
        endcase
        return m;
    endfunction

    // Store bytes touched by one pixel
    function automatic logic [2:0] fmt_bytes(input fmt_t fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_16BPP: n = 3'd2;
            FMT_24BPP: n = 3'd3;
            FMT_32BPP: n = 3'd4;
            default:   n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== design/ppx_ifs.sv =====
// Valid/ready channel interfaces: pixel requests, results and register writes.
interface ppx_req_if;
    import ppx_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, mode, pos_x, pos_y, pixel_value, input ready);
    modport sink   (input valid, mode, pos_x, pos_y, pixel_value, output ready);
endinterface

interface ppx_rsp_if;
    import ppx_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] read_value;
    logic             ok;

    modport source (output valid, read_value, ok, input ready);
    modport sink   (input valid, read_value, ok, output ready);
endinterface

interface ppx_cfg_if;
    import ppx_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ppx_front.sv =====
// Front end: request holding stage, range checks and byte address computation.
module ppx_front #(
    parameter int STORE_BYTES = ppx_pkg::STORE_BYTES_DEF,
    parameter int MAX_DIM     = ppx_pkg::MAX_DIM_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ppx_req_if.sink           req,
    input  ppx_pkg::ppx_cfg_t img_cfg,
    output ppx_pkg::ppx_cmd_t cmd,
    output logic              push,
    input  logic              full
);
    import ppx_pkg::*;

    logic             hold_valid_reg;
    logic             mode_reg;
    logic [POS_W-1:0] x_reg;
    logic [POS_W-1:0] y_reg;
    logic [PIX_W-1:0] value_reg;

    logic [17:0]       w18;
    logic [17:0]       row_bits;
    logic [17:0]       row_pad;
    logic [14:0]       stride;
    logic [DIM_W-1:0]  row_idx;
    logic [27:0]       row_base;
    logic [13:0]       x14;
    logic [13:0]       col_off;
    logic [CALC_W-1:0] addr_full;
    logic [CALC_W-1:0] end_addr;
    logic [2:0]        shift;
    logic              in_image;
    logic              dims_ok;

    // Holding stage: refills as soon as the held item moves to the queue
    assign push      = hold_valid_reg && !full;
    assign req.ready = !hold_valid_reg || !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            hold_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg  <= req.mode;
            x_reg     <= req.pos_x;
            y_reg     <= req.pos_y;
            value_reg <= req.pixel_value;
        end
    end

    // Row stride: bits per row rounded up to whole 32-bit words
    assign w18 = 18'(img_cfg.width);

    always_comb
    begin
        case (img_cfg.fmt)
            FMT_1BPP:  row_bits = w18;
            FMT_2BPP:  row_bits = w18 << 1;
            FMT_4BPP:  row_bits = w18 << 2;
            FMT_8BPP:  row_bits = w18 << 3;
            FMT_16BPP: row_bits = w18 << 4;
            FMT_24BPP: row_bits = (w18 << 4) + (w18 << 3);
            FMT_32BPP: row_bits = w18 << 5;
            default:   row_bits = '0;
        endcase
    end

    assign row_pad = row_bits + 18'd31;
    assign stride  = {row_pad[17:5], 2'b00};

    // Bottom-up images store row 0 last
    assign row_idx  = img_cfg.top_down ? DIM_W'(y_reg)
                                       : img_cfg.height - DIM_W'(1) - DIM_W'(y_reg);
    assign row_base = 28'(row_idx) * 28'(stride);

    // Byte offset of the pixel inside its row, and bit position for sub-byte pixels
    assign x14 = 14'(x_reg);

    always_comb
    begin
        shift = 3'd0;
        case (img_cfg.fmt)
            FMT_1BPP:
            begin
                col_off = x14 >> 3;
                shift   = ~x_reg[2:0];
            end
            FMT_2BPP:
            begin
                col_off = x14 >> 2;
                shift   = {~x_reg[1:0], 1'b0};
            end
            FMT_4BPP:
            begin
                col_off = x14 >> 1;
                shift   = {~x_reg[0], 2'b00};
            end
            FMT_16BPP: col_off = x14 << 1;
            FMT_24BPP: col_off = (x14 << 1) + x14;
            FMT_32BPP: col_off = x14 << 2;
            default:   col_off = x14;
        endcase
    end

    assign addr_full = CALC_W'(row_base) + CALC_W'(col_off);
    assign end_addr  = addr_full + CALC_W'(fmt_bytes(img_cfg.fmt));

    // Classification
    assign dims_ok  = !(32'(img_cfg.width) > 32'(MAX_DIM)) &&
                      !(32'(img_cfg.height) > 32'(MAX_DIM));
    assign in_image = (DIM_W'(x_reg) < img_cfg.width) && (DIM_W'(y_reg) < img_cfg.height);

    always_comb
    begin
        cmd.mode  = mode_reg;
        cmd.good  = (img_cfg.fmt != FMT_NONE) && dims_ok && in_image &&
                    (end_addr <= CALC_W'(STORE_BYTES));
        cmd.fmt   = img_cfg.fmt;
        cmd.shift = shift;
        cmd.addr  = addr_full[STORE_AW_MAX-1:0];
        cmd.value = value_reg;
    end

endmodule

// ===== design/ppx_queue.sv =====
// Command queue between front and back end.
module ppx_queue #(
    parameter int DEPTH = ppx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppx_pkg::ppx_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output ppx_pkg::ppx_cmd_t head
);
    import ppx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppx_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

// ===== design/ppx_back.sv =====
// Back end: banked byte store, read-modify-write sequencer and result register.
module ppx_back #(
    parameter int STORE_BYTES = ppx_pkg::STORE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ppx_pkg::ppx_cmd_t head,
    output logic              pop,
    ppx_rsp_if.source         rsp
);
    import ppx_pkg::*;

    localparam int BANK_DEPTH = (STORE_BYTES + LANES - 1) / LANES;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t             state_reg;
    ppx_cmd_t           cur_reg;
    logic [BANK_AW-1:0] row_reg [LANES];
    logic               rsp_valid_reg;
    logic [PIX_W-1:0]   read_value_reg;
    logic               ok_reg;

    logic [BANK_AW-1:0] base_row;
    logic [BANK_AW-1:0] issue_row [LANES];
    logic [1:0]         lane_idx [LANES];
    logic [LANES-1:0]   lane_act;
    logic [LANES-1:0]   lane_re;
    logic [LANES-1:0]   lane_we;
    logic [7:0]         lane_wdata [LANES];
    logic [7:0]         lane_rdata [LANES];
    logic               sub_byte;
    logic [7:0]         sub_old;
    logic [7:0]         sub_mask;
    logic [7:0]         sub_new;
    logic [PIX_W-1:0]   rv;
    logic               finish;

    assign pop    = (state_reg == S_IDLE) && head_valid;
    assign finish = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Issue: bank row per lane; lanes below the start lane wrap into the next word
    assign base_row = BANK_AW'(head.addr >> 2);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            issue_row[i] = base_row + ((2'(i) < head.addr[1:0]) ? BANK_AW'(1) : BANK_AW'(0));
            lane_re[i]   = pop && head.good;
        end
    end

    // Execute: lane byte positions and merged write data
    assign sub_byte = (cur_reg.fmt == FMT_1BPP) || (cur_reg.fmt == FMT_2BPP) ||
                      (cur_reg.fmt == FMT_4BPP);
    assign sub_old  = lane_rdata[cur_reg.addr[1:0]];
    assign sub_mask = fmt_mask(cur_reg.fmt) << cur_reg.shift;
    assign sub_new  = (sub_old & ~sub_mask) |
                      ((cur_reg.value[7:0] & fmt_mask(cur_reg.fmt)) << cur_reg.shift);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_idx[i]   = 2'(i) - cur_reg.addr[1:0];
            lane_act[i]   = {1'b0, lane_idx[i]} < fmt_bytes(cur_reg.fmt);
            lane_we[i]    = finish && cur_reg.good && cur_reg.mode && lane_act[i];
            lane_wdata[i] = sub_byte ? sub_new
                                     : 8'(cur_reg.value >> {lane_idx[i], 3'b000});
        end
    end

    // Result assembly
    always_comb
    begin
        rv = '0;
        if (sub_byte)
        begin
            rv = PIX_W'((sub_old >> cur_reg.shift) & fmt_mask(cur_reg.fmt));
        end
        else
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (lane_act[i])
                begin
                    rv = rv | (PIX_W'(lane_rdata[i]) << {lane_idx[i], 3'b000});
                end
            end
        end
        if (cur_reg.mode)
        begin
            rv = '0;
        end
        else if (!cur_reg.good)
        begin
            rv = '1;
        end
    end

    // Store banks: one byte lane each, registered read
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [7:0] mem [BANK_DEPTH];
        logic [7:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (lane_we[g])
            begin
                mem[row_reg[g]] <= lane_wdata[g];
            end
            if (lane_re[g])
            begin
                rd_reg <= mem[issue_row[g]];
            end
        end

        assign lane_rdata[g] = rd_reg;
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                row_reg[i] <= '0;
            end
            rsp_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            ok_reg         <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        cur_reg   <= head;
                        row_reg   <= issue_row;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (finish)
            begin
                rsp_valid_reg  <= 1'b1;
                read_value_reg <= rv;
                ok_reg         <= cur_reg.good;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.ok         = ok_reg;

`ifndef ASSERT_OFF
    a_write_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_we) |-> (state_reg == S_EXEC) && cur_reg.good && cur_reg.mode)
        else $error("store written by a failed or read item");
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised outside execute");
    a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !ok_reg) |-> (read_value_reg == '0) || (read_value_reg == '1))
        else $error("failed item carries a pixel value");
`endif

endmodule

// ===== design/packed_pixel_read_write_core.sv =====
// Packed pixel read/write engine: configuration registers, front end, queue, back end.
// Path from request accept to result valid: holding register, then queue write,
//   store read issue, and execute into the result register.
// Items: the back end takes a new item only after its read then
//   modify/write pass over the four byte-lane store banks is done.
// Reset: clears handshake and sequencing state and loads the registers with
//   width 1, height 1, unsupported format, bottom-up; store contents stay undefined.
module packed_pixel_read_write_core #(
    parameter int STORE_BYTES = ppx_pkg::STORE_BYTES_DEF,
    parameter int MAX_DIM     = ppx_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = ppx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ppx_req_if.sink   req,
    ppx_rsp_if.source rsp,
    ppx_cfg_if.sink   cfg
);
    import ppx_pkg::*;

    ppx_cfg_t img_cfg_reg;
    ppx_cmd_t front_cmd;
    ppx_cmd_t head_cmd;
    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_cfg_reg.width    <= DIM_W'(1);
            img_cfg_reg.height   <= DIM_W'(1);
            img_cfg_reg.fmt      <= FMT_NONE;
            img_cfg_reg.top_down <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_WIDTH:    img_cfg_reg.width    <= cfg.data[DIM_W-1:0];
                CFG_HEIGHT:   img_cfg_reg.height   <= cfg.data[DIM_W-1:0];
                CFG_FORMAT:   img_cfg_reg.fmt      <= fmt_t'(cfg.data[2:0]);
                CFG_TOP_DOWN: img_cfg_reg.top_down <= cfg.data[0];
                default:      img_cfg_reg          <= img_cfg_reg;
            endcase
        end
    end

    ppx_front #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_DIM     (MAX_DIM)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .img_cfg (img_cfg_reg),
        .cmd     (front_cmd),
        .push    (push),
        .full    (full)
    );

    ppx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (front_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head_cmd)
    );

    ppx_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_cmd),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

// ===== sim/tb_packed_pixel_read_write_core.sv =====
// Testbench for the packed pixel access engine: directed and random accesses against a shadow store.
module tb_packed_pixel_read_write_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ppx_pkg::*;

    localparam int ITEM_TARGET    = 850;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RECENT_DEPTH   = 32;
    // Bytes at the start of the store that get written before any sub-byte access
    localparam int FILL_BYTES     = 512;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int DATA_MAX       = (1 << CFG_DATA_W) - 1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;
    // No register lives at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    typedef struct {
        logic             mode;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] value;
    } pixel_req_t;

    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } pixel_pos_t;

    // Shadow of the image registers and the byte store, plus the results still owed
    class frame_store_shadow;
        int unsigned      width;
        int unsigned      height;
        fmt_t             fmt;
        bit               top_down;
        byte unsigned     bytes[int unsigned];
        logic [PIX_W-1:0] want_value[$];
        logic             want_ok[$];
        pixel_pos_t       stored_pos[$];
        int unsigned      errors;

        function new();
            width    = 1;
            height   = 1;
            fmt      = FMT_NONE;
            top_down = 1'b0;
            errors   = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIDTH:    width = 32'(data);
                CFG_HEIGHT:   height = 32'(data);
                CFG_FORMAT:   fmt = fmt_t'(data[2:0]);
                CFG_TOP_DOWN: top_down = data[0];
                default: ;
            endcase
            stored_pos.delete();
        endfunction

        function int unsigned bpp_of(input fmt_t f);
            case (f)
                FMT_1BPP:  return 1;
                FMT_2BPP:  return 2;
                FMT_4BPP:  return 4;
                FMT_8BPP:  return 8;
                FMT_16BPP: return 16;
                FMT_24BPP: return 24;
                FMT_32BPP: return 32;
                default:   return 0;
            endcase
        endfunction

        function int unsigned bits_per_pixel();
            return bpp_of(fmt);
        endfunction

        // Row pitch in bytes, padded to whole 32-bit words
        function int unsigned stride();
            return ((width * bits_per_pixel() + 31) / 32) * 4;
        endfunction

        // Byte address, byte count and sub-byte field of a pixel; 0 on any error
        function bit locate(input pixel_req_t r, output int unsigned addr,
                            output int unsigned nbytes, output int unsigned shift,
                            output logic [7:0] field);
            int unsigned bpp;
            int unsigned row;
            bpp    = bits_per_pixel();
            addr   = 0;
            nbytes = 1;
            shift  = 0;
            field  = 8'hFF;
            if (bpp == 0 || width > MAX_DIM_DEF || height > MAX_DIM_DEF ||
                r.x >= width || r.y >= height)
                return 1'b0;
            row = top_down ? r.y : (height - 1 - r.y);
            row = row * stride();
            if (bpp < 8)
            begin
                addr = row + (r.x * bpp) / 8;
                // leftmost pixel sits in the high bits
                case (bpp)
                    1:
                    begin
                        shift = 7 - r.x[2:0];
                        field = 8'h01;
                    end
                    2:
                    begin
                        shift = 6 - 2 * r.x[1:0];
                        field = 8'h03;
                    end
                    default:
                    begin
                        shift = r.x[0] ? 0 : 4;
                        field = 8'h0F;
                    end
                endcase
            end
            else
            begin
                nbytes = bpp / 8;
                addr   = row + r.x * nbytes;
            end
            return (addr + nbytes <= STORE_BYTES_DEF);
        endfunction

        // True when the access reads no store byte that was never written
        function bit safe(input pixel_req_t r);
            int unsigned addr;
            int unsigned nbytes;
            int unsigned shift;
            logic [7:0]  field;
            if (!locate(r, addr, nbytes, shift, field))
                return 1'b1;
            if (r.mode == MODE_WRITE && bits_per_pixel() >= 8)
                return 1'b1;
            for (int unsigned i = 0; i < nbytes; i++)
                if (!bytes.exists(addr + i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_request(input pixel_req_t r);
            int unsigned      addr;
            int unsigned      nbytes;
            int unsigned      shift;
            logic [7:0]       field;
            logic [7:0]       b;
            logic [7:0]       keep;
            logic [PIX_W-1:0] rv;
            bit               good;
            good = locate(r, addr, nbytes, shift, field);
            rv   = '0;
            if (good && bits_per_pixel() < 8)
            begin
                // sub-byte: read-modify-write keeps the neighbors
                b = bytes[addr];
                if (r.mode == MODE_WRITE)
                begin
                    keep        = ~(field << shift);
                    bytes[addr] = (b & keep) | ((r.value[7:0] & field) << shift);
                end
                else
                    rv = PIX_W'((b >> shift) & field);
            end
            else if (good)
            begin
                // little endian multi-byte pixel
                for (int unsigned i = 0; i < nbytes; i++)
                begin
                    if (r.mode == MODE_WRITE)
                        bytes[addr + i] = r.value[8*i +: 8];
                    else
                        rv[8*i +: 8] = bytes[addr + i];
                end
            end
            if (r.mode == MODE_WRITE)
                rv = '0;
            else if (!good)
                rv = '1;
            want_value.push_back(rv);
            want_ok.push_back(good);
            if (good && r.mode == MODE_WRITE)
            begin
                stored_pos.push_back('{r.x, r.y});
                if (stored_pos.size() > RECENT_DEPTH)
                    void'(stored_pos.pop_front());
            end
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(input logic [PIX_W-1:0] rv, input logic ok);
            logic [PIX_W-1:0] v;
            logic             k;
            if (want_value.size() == 0)
            begin
                report($sformatf("unexpected item read_value %h ok %b", rv, ok));
                return;
            end
            v = want_value.pop_front();
            k = want_ok.pop_front();
            if (rv !== v)
                report($sformatf("read_value %h, predicted %h", rv, v));
            if (ok !== k)
                report($sformatf("ok %b, predicted %b", ok, k));
        endtask

        function int unsigned pending();
            return want_value.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ppx_req_if req_ch();
    ppx_rsp_if rsp_ch();
    ppx_cfg_if cfg_ch();

    frame_store_shadow shadow = new();

    bit          req_idle;
    bit          rsp_idle;
    bit          rsp_hold;
    int unsigned sent_items;
    int unsigned idle_cycles;

    packed_pixel_read_write_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: random stalls, one long hold on request
    initial
    begin : result_sink
        int unsigned gap;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = rsp_idle ? $urandom_range(0, 18) : 0;
            if (rsp_hold)
            begin
                gap      = HOLD_CYCLES;
                rsp_hold = 1'b0;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
            shadow.check_result(rsp_ch.read_value, rsp_ch.ok);
        end
    end

    task automatic send_request(input pixel_req_t r);
        int unsigned gap;
        gap = req_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= r.mode;
        req_ch.pos_x       <= r.x;
        req_ch.pos_y       <= r.y;
        req_ch.pixel_value <= r.value;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        shadow.note_request(r);
        sent_items++;
    endtask

    // Stop offering and wait until every owed result is in
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (shadow.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        shadow.set_register(idx, data);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input fmt_t f, input bit td);
        write_reg(CFG_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(CFG_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(CFG_FORMAT, CFG_DATA_W'(f));
        write_reg(CFG_TOP_DOWN, CFG_DATA_W'(td));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_coord(input int unsigned dim);
        int unsigned top;
        top = (dim > POS_MAX + 1) ? POS_MAX + 1 : dim;
        case ($urandom_range(0, 9))
            0: return POS_W'($urandom_range(0, POS_MAX));
            1: return POS_W'((top > POS_MAX) ? POS_MAX : top);   // just past the edge
            2: return '0;
            3: return POS_W'((top == 0) ? POS_MAX : top - 1);     // last column or row
            default: return POS_W'((top == 0) ? $urandom_range(0, POS_MAX)
                                              : $urandom_range(0, top - 1));
        endcase
    endfunction

    // Rows around the end of the store for the big images
    function automatic logic [POS_W-1:0] pick_row();
        int unsigned pitch;
        int unsigned r;
        pitch = shadow.stride();
        if (pitch == 0 || shadow.height > MAX_DIM_DEF || $urandom_range(0, 3) != 0)
            return pick_coord(shadow.height);
        r = STORE_BYTES_DEF / pitch - $urandom_range(0, 1);
        if (r >= shadow.height)
            return pick_coord(shadow.height);
        return POS_W'(shadow.top_down ? r : shadow.height - 1 - r);
    endfunction

    function automatic pixel_req_t random_request();
        pixel_req_t r;
        pixel_pos_t p;
        r.mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: r.value = '0;
            1: r.value = '1;
            default: r.value = $urandom;
        endcase
        r.x = pick_coord(shadow.width);
        r.y = pick_row();
        // revisit pixels written in this phase, and steer away from unwritten bytes
        if (shadow.stored_pos.size() > 0 && (!shadow.safe(r) || $urandom_range(0, 3) == 0))
        begin
            p   = shadow.stored_pos[$urandom_range(0, shadow.stored_pos.size() - 1)];
            r.x = p.x;
            r.y = p.y;
        end
        if (!shadow.safe(r))
            r.mode = MODE_WRITE;
        return r;
    endfunction

    task automatic random_config();
        int unsigned w;
        int unsigned h;
        int unsigned smax;
        int unsigned wmax;
        fmt_t        f;
        bit          td;
        td = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            6, 7:
            begin
                // large byte-aligned image, much of it past the store
                f = fmt_t'($urandom_range(FMT_8BPP, FMT_32BPP));
                w = $urandom_range(0, 1) ? MAX_DIM_DEF : $urandom_range(1, MAX_DIM_DEF);
                h = $urandom_range(0, 1) ? MAX_DIM_DEF : $urandom_range(1, MAX_DIM_DEF);
            end
            8:
            begin
                // bad dimensions: every access fails
                f = fmt_t'($urandom_range(FMT_1BPP, FMT_32BPP));
                w = $urandom_range(1, 64);
                h = $urandom_range(1, 32);
                case ($urandom_range(0, 3))
                    0: w = 0;
                    1: w = $urandom_range(MAX_DIM_DEF + 1, DATA_MAX);
                    2: h = 0;
                    default: h = DATA_MAX;
                endcase
            end
            9:
            begin
                f = FMT_NONE;
                w = $urandom_range(1, MAX_DIM_DEF);
                h = $urandom_range(1, MAX_DIM_DEF);
            end
            default:
            begin
                // image that fits the filled part of the store
                f    = fmt_t'($urandom_range(FMT_1BPP, FMT_32BPP));
                h    = $urandom_range(1, 32);
                smax = (FILL_BYTES / h) / 4 * 4;
                wmax = smax * 8 / shadow.bpp_of(f);
                if (wmax > MAX_DIM_DEF)
                    wmax = MAX_DIM_DEF;
                w = $urandom_range(0, 1) ? wmax : $urandom_range(1, wmax);
            end
        endcase
        configure(w, h, f, td);
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned count;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_READ;
        req_ch.pos_x       <= '0;
        req_ch.pos_y       <= '0;
        req_ch.pixel_value <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_WIDTH;
        cfg_ch.data        <= '0;
        req_idle           = 1'b1;
        rsp_idle           = 1'b1;
        rsp_hold           = 1'b0;
        sent_items         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset format is unsupported: both kinds of access fail
        send_request('{MODE_READ, 12'd0, 12'd0, 32'h0});
        send_request('{MODE_WRITE, 12'd0, 12'd0, 32'hFFFF_FFFF});
        settle();
        // Write to a register index that does not exist
        write_reg(CFG_UNUSED, CFG_DATA_W'(DATA_MAX));
        cfg_ch.valid <= 1'b0;
        send_request('{MODE_READ, 12'd0, 12'd0, 32'h0});
        settle();

        // Fill the start of the store so sub-byte accesses never see unwritten bytes
        configure(8, 16, FMT_32BPP, 1'b1);
        for (int unsigned y = 0; y < 16; y++)
            for (int unsigned x = 0; x < 8; x++)
                send_request('{MODE_WRITE, x[POS_W-1:0], y[POS_W-1:0], $urandom});
        settle();

        // 4 bpp: nibble picked by column parity, even column high
        configure(30, 32, FMT_4BPP, 1'b0);
        send_request('{MODE_WRITE, 12'd0, 12'd0, 32'hFFFF_FFFF});
        send_request('{MODE_WRITE, 12'd1, 12'd0, 32'h0});
        send_request('{MODE_READ, 12'd0, 12'd0, 32'h0});
        send_request('{MODE_READ, 12'd1, 12'd0, 32'h0});
        send_request('{MODE_WRITE, 12'd29, 12'd31, 32'h5});
        send_request('{MODE_READ, 12'd29, 12'd31, 32'h0});
        settle();

        // 1 bpp: both ends of a byte
        configure(100, 32, FMT_1BPP, 1'b1);
        send_request('{MODE_WRITE, 12'd7, 12'd2, 32'h1});
        send_request('{MODE_WRITE, 12'd0, 12'd2, 32'h0});
        send_request('{MODE_READ, 12'd7, 12'd2, 32'h0});
        send_request('{MODE_READ, 12'd6, 12'd2, 32'h0});
        settle();

        configure(60, 32, FMT_2BPP, 1'b0);
        send_request('{MODE_WRITE, 12'd3, 12'd5, 32'hFFFF_FFFF});
        send_request('{MODE_READ, 12'd3, 12'd5, 32'h0});
        settle();

        // Zero width, then a height above the limit
        configure(0, 4, FMT_8BPP, 1'b1);
        send_request('{MODE_READ, 12'd0, 12'd0, 32'h0});
        settle();
        configure(10, MAX_DIM_DEF + 904, FMT_8BPP, 1'b1);
        send_request('{MODE_READ, 12'd0, 12'd0, 32'h0});
        settle();

        // 32 bpp: last pixel that fits the store exactly, then past it
        configure(MAX_DIM_DEF, MAX_DIM_DEF, FMT_32BPP, 1'b1);
        send_request('{MODE_WRITE, 12'd4095, 12'd15, 32'hFFFF_FFFF});
        send_request('{MODE_READ, 12'd4095, 12'd15, 32'h0});
        send_request('{MODE_WRITE, 12'd0, 12'd16, 32'h0});
        send_request('{MODE_READ, 12'd4095, 12'd4095, 32'h0});
        settle();

        // 24 bpp: pixel straddling the end of the store, and its neighbor
        configure(MAX_DIM_DEF, MAX_DIM_DEF, FMT_24BPP, 1'b1);
        send_request('{MODE_WRITE, 12'd1365, 12'd21, 32'h1234_5678});
        send_request('{MODE_WRITE, 12'd1364, 12'd21, 32'hA55A_C33C});
        send_request('{MODE_READ, 12'd1364, 12'd21, 32'h0});
        settle();

        // 8 bpp bottom-up: row 0 is the last row, its last byte ends the store
        configure(MAX_DIM_DEF, 64, FMT_8BPP, 1'b0);
        send_request('{MODE_WRITE, 12'd4095, 12'd0, 32'h0000_00C3});
        send_request('{MODE_READ, 12'd4095, 12'd0, 32'h0});
        send_request('{MODE_READ, 12'd0, 12'd64, 32'h0});
        settle();

        // Random phases; the first runs flat out against a long result hold
        phase = 0;
        while (sent_items < ITEM_TARGET)
        begin
            random_config();
            req_idle = ($urandom_range(0, 2) != 0);
            rsp_idle = ($urandom_range(0, 2) != 0);
            count    = $urandom_range(25, 60);
            if (phase == 0)
            begin
                req_idle = 1'b0;
                rsp_idle = 1'b0;
                rsp_hold = 1'b1;
                count    = 60;
            end
            repeat (count) send_request(random_request());
            settle();
            phase++;
        end

        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
